@@ rtl/core/fxalu_pkg.sv @@
package fxalu_pkg;

  // operation codes carried in the low nibble of the input beat
  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_LT       = 4'd4,
    ACT_GT       = 4'd5,
    ACT_LE       = 4'd6,
    ACT_GE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_e;

  localparam int unsigned DataW    = 32;
  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 40;

endpackage

@@ rtl/core/fixed_point_q24_8_alu_unit.sv @@
// Signed fixed-point ALU, 32-bit two's complement with FRACTION_BITS fraction bits
// (Q24.8 by default). One beat in gives one beat out, in order. The pipeline takes
// a new beat every cycle unless the output is stalled; every operation passes
// through the same stages: one stage for the 32x32 multiplier and operand preparation,
// 32 + FRACTION_BITS stages of the restoring divider, one quotient bit per stage,
// and one output stage. All operations flow through the same depth so results
// leave in order. A stalled output freezes the whole pipeline; nothing is dropped.
// Division by zero gives result 0 with divide_by_zero set.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] action, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] result_value, [32] compare_true, [33] divide_by_zero, [39:34] zero
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned NB = 32 + FRACTION_BITS;

  typedef struct packed {
    logic [3:0]    act;
    logic [31:0]   res;
    logic          cmp;
    logic          dz;
    logic [31:0]   rem;
    logic [NB-1:0] nq;
    logic [31:0]   dvs;
    logic          neg;
  } dstage_t;

  logic en;

  // input unpack
  logic        [3:0]  in_act;
  logic signed [31:0] in_a;
  logic signed [31:0] in_b;
  assign in_act = s_axis_tdata_i[3:0];
  assign in_a   = s_axis_tdata_i[35:4];
  assign in_b   = s_axis_tdata_i[67:36];

  // whole pipeline advances unless the output beat is stuck
  logic vo_q;
  assign en              = !vo_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage one: multiplier, simple operations, divider set-up
  dstage_t            s1_d, s1_q;
  logic               s1_vld_q;
  logic signed [63:0] prod_d, prod_q;
  logic        [31:0] amag, bmag;
  logic signed [32:0] tint_sum;

  always_comb begin
    amag     = in_a[31] ? (32'd0 - in_a) : in_a;
    bmag     = in_b[31] ? (32'd0 - in_b) : in_b;
    prod_d   = 64'(in_a) * 64'(in_b);
    tint_sum = 33'(in_a) + (in_a[31] ? 33'((33'd1 << FRACTION_BITS) - 33'd1) : 33'd0);
    s1_d     = '0;
    s1_d.act = in_act;
    s1_d.nq  = {amag, FRACTION_BITS'(0)};
    s1_d.dvs = bmag;
    s1_d.neg = in_a[31] ^ in_b[31];
    unique case (fxalu_pkg::action_e'(in_act))
      fxalu_pkg::ACT_ADD:      s1_d.res = in_a + in_b;
      fxalu_pkg::ACT_SUB:      s1_d.res = in_a - in_b;
      fxalu_pkg::ACT_MUL:      s1_d.res = '0;
      fxalu_pkg::ACT_DIV:      s1_d.dz  = (in_b == 32'sd0);
      fxalu_pkg::ACT_LT:       s1_d.cmp = in_a < in_b;
      fxalu_pkg::ACT_GT:       s1_d.cmp = in_a > in_b;
      fxalu_pkg::ACT_LE:       s1_d.cmp = in_a <= in_b;
      fxalu_pkg::ACT_GE:       s1_d.cmp = in_a >= in_b;
      fxalu_pkg::ACT_EQ:       s1_d.cmp = in_a == in_b;
      fxalu_pkg::ACT_NE:       s1_d.cmp = in_a != in_b;
      fxalu_pkg::ACT_MIN:      s1_d.res = (in_a <= in_b) ? in_a : in_b;
      fxalu_pkg::ACT_MAX:      s1_d.res = (in_a >= in_b) ? in_a : in_b;
      fxalu_pkg::ACT_INC:      s1_d.res = in_a + 32'sd1;
      fxalu_pkg::ACT_DEC:      s1_d.res = in_a - 32'sd1;
      fxalu_pkg::ACT_FROM_INT: s1_d.res = in_a << FRACTION_BITS;
      fxalu_pkg::ACT_TO_INT:   s1_d.res = 32'(tint_sum >>> FRACTION_BITS);
      default:                 s1_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      prod_q <= prod_d;
    end
  end

  // divider stages, one quotient bit each
  dstage_t st_in [NB];
  dstage_t st_d  [NB];
  dstage_t st_q  [NB];
  logic    vld_in [NB];
  logic    vld_q  [NB];

  for (genvar k = 0; k < NB; k++) begin : g_div
    logic [32:0] sh;
    logic [32:0] diff;

    if (k == 0) begin : g_first
      always_comb begin
        st_in[k] = s1_q;
        if (s1_q.act == fxalu_pkg::ACT_MUL) begin
          st_in[k].res = prod_q[FRACTION_BITS+31:FRACTION_BITS];
        end
      end
      assign vld_in[k] = s1_vld_q;
    end else begin : g_next
      assign st_in[k]  = st_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    always_comb begin
      sh      = {st_in[k].rem, st_in[k].nq[NB-1]};
      diff    = sh - {1'b0, st_in[k].dvs};
      st_d[k] = st_in[k];
      if (sh >= {1'b0, st_in[k].dvs}) begin
        st_d[k].rem = diff[31:0];
        st_d[k].nq  = {st_in[k].nq[NB-2:0], 1'b1};
      end else begin
        st_d[k].rem = sh[31:0];
        st_d[k].nq  = {st_in[k].nq[NB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // output stage: sign fix of the quotient and final select
  dstage_t     last;
  logic [31:0] res_d, res_q;
  logic        cmp_q, dz_q;

  assign last = st_q[NB-1];

  always_comb begin
    res_d = last.res;
    if (last.act == fxalu_pkg::ACT_DIV) begin
      if (last.dz) begin
        res_d = '0;
      end else if (last.neg) begin
        res_d = 32'd0 - last.nq[31:0];
      end else begin
        res_d = last.nq[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vld_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      cmp_q <= last.cmp;
      dz_q  <= last.dz;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {6'd0, dz_q, cmp_q, res_q};

  // checks
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && dz_q) |-> (res_q == 32'd0))
    else $error("divide by zero with non-zero result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !(dz_q && cmp_q))
    else $error("compare and divide flags both set");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_vld_q) && $stable(vld_q[NB-1])))
    else $error("pipeline moved during stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !m_axis_tready_i) |=> $stable(res_q))
    else $error("stalled result changed");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FracBits = 8;
  localparam int unsigned NumRandom = 550;
  localparam int unsigned MaxErrShown = 10;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_res_t;

  // scoreboard: predicts each accepted beat and checks results in order
  class alu_scoreboard;
    alu_res_t pending_q[$];
    int unsigned err_cnt;

    function alu_res_t predict(fxalu_pkg::action_e act, logic signed [31:0] a,
                               logic signed [31:0] b);
      alu_res_t r;
      logic signed [63:0] wide;
      logic signed [63:0] num;
      r = '0;
      case (act)
        fxalu_pkg::ACT_ADD: r.value = a + b;
        fxalu_pkg::ACT_SUB: r.value = a - b;
        fxalu_pkg::ACT_MUL: begin
          wide = 64'(a) * 64'(b);
          r.value = 32'(wide >>> FracBits);
        end
        fxalu_pkg::ACT_DIV: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            num = 64'(a) <<< FracBits;
            wide = num / 64'(b);
            r.value = wide[31:0];
          end
        end
        fxalu_pkg::ACT_LT: r.cmp = a < b;
        fxalu_pkg::ACT_GT: r.cmp = a > b;
        fxalu_pkg::ACT_LE: r.cmp = a <= b;
        fxalu_pkg::ACT_GE: r.cmp = a >= b;
        fxalu_pkg::ACT_EQ: r.cmp = a == b;
        fxalu_pkg::ACT_NE: r.cmp = a != b;
        fxalu_pkg::ACT_MIN: r.value = (a <= b) ? a : b;
        fxalu_pkg::ACT_MAX: r.value = (a >= b) ? a : b;
        fxalu_pkg::ACT_INC: r.value = a + 32'sd1;
        fxalu_pkg::ACT_DEC: r.value = a - 32'sd1;
        fxalu_pkg::ACT_FROM_INT: r.value = a << FracBits;
        default: begin
          wide = 64'(a) / (64'sd1 <<< FracBits);
          r.value = wide[31:0];
        end
      endcase
      return r;
    endfunction

    function void note_input(logic [71:0] beat);
      pending_q.push_back(predict(fxalu_pkg::action_e'(beat[3:0]), beat[35:4], beat[67:36]));
    endfunction

    function void check_result(logic [39:0] beat);
      alu_res_t got;
      alu_res_t want;
      got = '{value: beat[31:0], cmp: beat[32], dz: beat[33]};
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxErrShown) $display("unexpected result beat %h", beat);
        return;
      end
      want = pending_q.pop_front();
      if (got != want || beat[39:34] != 0) begin
        err_cnt++;
        if (err_cnt <= MaxErrShown)
          $display("result mismatch: exp value %h cmp %b dz %b, got value %h cmp %b dz %b",
                   want.value, want.cmp, want.dz, got.value, got.cmp, got.dz);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  alu_scoreboard sb = new();
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  fixed_point_q24_8_alu_unit #(.FRACTION_BITS(FracBits)) dut (.*);

  // note accepted beats on both sides
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_input(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // random back pressure on the result side
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= calm || ($urandom_range(99) >= 31);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(2047)) - 1024);
      4: return 32'($signed($urandom_range(255)) - 128) << FracBits;
      default: return $urandom();
    endcase
  endfunction

  // drive one beat, with a random gap before it unless in a calm stretch
  task automatic send_beat(fxalu_pkg::action_e act, logic [31:0] a, logic [31:0] b);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, b, a, act};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] ext [4];
    fxalu_pkg::action_e act;
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation on extremes, plus zero divisor and negative truncation
    for (int i = 0; i < 16; i++) begin
      send_beat(fxalu_pkg::action_e'(i), ext[i % 4], ext[(i + 1) % 4]);
    end
    send_beat(fxalu_pkg::ACT_DIV, 32'h0000_0100, 32'h0);
    send_beat(fxalu_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(fxalu_pkg::ACT_DIV, 32'hffff_ff00, 32'h0000_0300);
    send_beat(fxalu_pkg::ACT_TO_INT, 32'hffff_fe80, 32'h0);
    send_beat(fxalu_pkg::ACT_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_beat(fxalu_pkg::ACT_EQ, 32'h1234_5678, 32'h1234_5678);
    send_beat(fxalu_pkg::ACT_MIN, 32'h5, 32'h5);

    // random: the middle third runs without idling
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= NumRandom / 3) && (n < 2 * NumRandom / 3);
      act = fxalu_pkg::action_e'($urandom_range(15));
      send_beat(act, pick_operand(), ($urandom_range(15) == 0) ? 32'h0 : pick_operand());
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run once the pipeline has drained
  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.err_cnt == 0) begin
      $display("fixed_point_q24_8_alu_unit: match");
    end else begin
      $display("fixed_point_q24_8_alu_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("fixed_point_q24_8_alu_unit: mismatch");
    $finish;
  end

endmodule
